### design/rdsc_pkg.sv
// ----------------------------------------------------------------------------
// rdsc_pkg: shared types and helpers for the dual-sum image checksum fixer
// Widths, register map, reset values, check-range and check-value functions.
// ----------------------------------------------------------------------------
package rdsc_pkg;

    // field widths
    localparam int ADDR_BITS   = 24;
    localparam int WORD_BITS   = 32;
    localparam int IN_TDATA_W  = ((WORD_BITS + ADDR_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 2 * WORD_BITS;
    localparam int OUT_TUSER_W = 3;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_BALANCE_ADDRESS = 2'd0;
    localparam logic [1:0] REG_SUM_TARGET      = 2'd1;
    localparam logic [1:0] REG_CHECK_ADDRESS   = 2'd2;

    // register reset values
    localparam logic [ADDR_BITS-1:0] BALANCE_ADDRESS_RST = ADDR_BITS'(32'h0000_8020);
    localparam logic [WORD_BITS-1:0] SUM_TARGET_RST      = 32'h5aa5_a55a;
    localparam logic [ADDR_BITS-1:0] CHECK_ADDRESS_RST   = ADDR_BITS'(32'h0000_8000);

    // last byte offset of the two check words
    localparam int CHECK_SPAN = 7;

    typedef struct packed {
        logic [ADDR_BITS-1:0] balance_address;
        logic [WORD_BITS-1:0] sum_target;
        logic [ADDR_BITS-1:0] check_address;
    } cfg_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] region_sum;
        logic [WORD_BITS-1:0] checked_sum;
        logic [WORD_BITS-1:0] stored_balance;
        logic [WORD_BITS-1:0] stored_check;
    } sums_t;

    // address lies in the eight-byte check range, no wrap at the top
    function automatic logic in_check_range(input logic [ADDR_BITS-1:0] addr,
                                            input logic [ADDR_BITS-1:0] base);
        logic [ADDR_BITS:0] hi;
        hi = {1'b0, base} + (ADDR_BITS + 1)'(CHECK_SPAN);
        return (addr >= base) && ({1'b0, addr} <= hi);
    endfunction

    // upper bytes are 0xff minus the byte, low byte is 0x100 minus the byte
    function automatic logic [WORD_BITS-1:0] check_value(input logic [WORD_BITS-1:0] s);
        logic [8:0] low;
        low = 9'h100 - {1'b0, s[7:0]};
        return {8'hff - s[31:24], 8'hff - s[23:16], 8'hff - s[15:8], low[7:0]};
    endfunction

endpackage

### design/rdsc_cfg.sv
// ----------------------------------------------------------------------------
// rdsc_cfg: configuration registers
// APB-style register file holding balance address, sum target, check address.
// ----------------------------------------------------------------------------
module rdsc_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rdsc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rdsc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rdsc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output rdsc_pkg::cfg_t                  cfg
);
    import rdsc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_BALANCE_ADDRESS: cfg_next.balance_address = pwdata[ADDR_BITS-1:0];
                REG_SUM_TARGET:      cfg_next.sum_target      = pwdata[WORD_BITS-1:0];
                REG_CHECK_ADDRESS:   cfg_next.check_address   = pwdata[ADDR_BITS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.balance_address <= BALANCE_ADDRESS_RST;
            cfg_reg.sum_target      <= SUM_TARGET_RST;
            cfg_reg.check_address   <= CHECK_ADDRESS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        unique case (reg_idx)
            REG_BALANCE_ADDRESS: prdata = APB_DATA_W'(cfg_reg.balance_address);
            REG_SUM_TARGET:      prdata = APB_DATA_W'(cfg_reg.sum_target);
            REG_CHECK_ADDRESS:   prdata = APB_DATA_W'(cfg_reg.check_address);
            default:             prdata = '0;
        endcase
    end

endmodule

### design/rdsc_accum.sv
// ----------------------------------------------------------------------------
// rdsc_accum: input register and running sums
// Registers each word with its address compares, then folds it into the two
// sums and the captured words; on the last word the totals move to a hand-off
// register and the sums clear.
// ----------------------------------------------------------------------------
module rdsc_accum (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rdsc_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                            s_tlast,
    input  rdsc_pkg::cfg_t                  cfg,
    output logic                            fin_valid,
    input  logic                            fin_ready,
    output rdsc_pkg::sums_t                 fin_sums
);
    import rdsc_pkg::*;

    logic [WORD_BITS-1:0] in_word;
    logic [ADDR_BITS-1:0] in_addr;

    // input stage
    logic                 in_valid_reg, in_valid_next;
    logic [WORD_BITS-1:0] word_reg;
    logic                 last_reg;
    logic                 ge_bal_reg;
    logic                 in_chk_reg;
    logic                 eq_bal_reg;
    logic                 eq_chk_reg;

    // running state and hand-off
    sums_t acc_reg, acc_next, acc_upd;
    logic  fin_valid_reg, fin_valid_next;
    sums_t fin_sums_reg;

    logic accept;
    logic hand_ready;
    logic consume;

    assign in_word = s_tdata[WORD_BITS-1:0];
    assign in_addr = s_tdata[WORD_BITS +: ADDR_BITS];

    // a non-last word never waits; a last word waits for the hand-off slot
    assign hand_ready = !fin_valid_reg || fin_ready;
    assign consume    = in_valid_reg && (!last_reg || hand_ready);
    assign s_tready   = !in_valid_reg || consume;
    assign accept     = s_tvalid && s_tready;

    assign in_valid_next  = accept || (in_valid_reg && !consume);
    assign fin_valid_next = (consume && last_reg) || (fin_valid_reg && !fin_ready);

    // sums and captures with the registered word folded in
    always_comb
    begin
        acc_upd = acc_reg;
        if (ge_bal_reg)
        begin
            acc_upd.region_sum = acc_reg.region_sum + word_reg;
        end
        if (!in_chk_reg)
        begin
            acc_upd.checked_sum = acc_reg.checked_sum + word_reg;
        end
        if (eq_bal_reg)
        begin
            acc_upd.stored_balance = word_reg;
        end
        if (eq_chk_reg)
        begin
            acc_upd.stored_check = word_reg;
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (consume)
        begin
            acc_next = last_reg ? '0 : acc_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            fin_valid_reg <= 1'b0;
            acc_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            fin_valid_reg <= fin_valid_next;
            acc_reg       <= acc_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg   <= in_word;
            last_reg   <= s_tlast;
            ge_bal_reg <= in_addr >= cfg.balance_address;
            in_chk_reg <= in_check_range(in_addr, cfg.check_address);
            eq_bal_reg <= in_addr == cfg.balance_address;
            eq_chk_reg <= in_addr == cfg.check_address;
        end
        if (consume && last_reg)
        begin
            fin_sums_reg <= acc_upd;
        end
    end

    assign fin_valid = fin_valid_reg;
    assign fin_sums  = fin_sums_reg;

endmodule

### design/rdsc_finish.sv
// ----------------------------------------------------------------------------
// rdsc_finish: result forming and output register
// Corrects the balance word, checks and recomputes the check word, and holds
// the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module rdsc_finish (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rdsc_pkg::cfg_t                   cfg,
    input  logic                             fin_valid,
    output logic                             fin_ready,
    input  rdsc_pkg::sums_t                  fin_sums,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rdsc_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [rdsc_pkg::OUT_TUSER_W-1:0] m_tuser
);
    import rdsc_pkg::*;

    logic [WORD_BITS-1:0] diff;
    logic [WORD_BITS-1:0] new_bal;
    logic [WORD_BITS-1:0] computed;
    logic [WORD_BITS-1:0] resum;
    logic [WORD_BITS-1:0] chk;
    logic                 bfix;
    logic                 cfix;
    logic                 bal_in_chk;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TUSER_W-1:0] m_tuser_reg;
    logic                   load;

    // balance correction
    assign diff    = cfg.sum_target - fin_sums.region_sum;
    assign new_bal = fin_sums.stored_balance + diff;
    assign bfix    = fin_sums.region_sum != cfg.sum_target;

    // check word: keep the stored one if it matches, else recompute
    assign computed   = check_value(fin_sums.checked_sum);
    assign cfix       = computed != fin_sums.stored_check;
    assign bal_in_chk = in_check_range(cfg.balance_address, cfg.check_address);
    assign resum      = bal_in_chk ? fin_sums.checked_sum : fin_sums.checked_sum + diff;
    assign chk        = cfix ? check_value(resum) : fin_sums.stored_check;

    // output register handshake
    assign fin_ready     = !m_tvalid_reg || m_tready;
    assign load          = fin_valid && fin_ready;
    assign m_tvalid_next = fin_valid || (m_tvalid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_tdata_reg <= {chk, new_bal};
            m_tuser_reg <= {!bfix && !cfix, cfix, bfix};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### design/rom_dual_sum_checksum_fixer.sv
// ----------------------------------------------------------------------------
// rom_dual_sum_checksum_fixer: dual-sum image checksum checker and fixer
// Streams image words, keeps two sums and gives a fixed balance and check word.
// ----------------------------------------------------------------------------
// The block takes one image word per clock, every cycle, with no stall while
// the output is free: s_tready only drops when the output and hand-off
// registers both hold unread results and a further last word sits in the
// input register. A non-last word gives no result. A last word gives its
// result on m_tdata/m_tuser through the input register, hand-off register
// and output register in turn; the sums clear with it, so the first word
// of the next image may follow in the next cycle.
// Configuration registers should only be written while no image is in flight.
module rom_dual_sum_checksum_fixer (
    input  logic                             clk,
    input  logic                             rst_n,
    // image word stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [rdsc_pkg::IN_TDATA_W-1:0]  s_tdata,   // rom_word, word_address
    input  logic                             s_tlast,   // last_word
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [rdsc_pkg::OUT_TDATA_W-1:0] m_tdata,   // balance_word, check_word
    output logic [rdsc_pkg::OUT_TUSER_W-1:0] m_tuser,   // balance_fixed, check_fixed,
                                                        // image_ok
    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rdsc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rdsc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rdsc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import rdsc_pkg::*;

    cfg_t  cfg;
    logic  fin_valid;
    logic  fin_ready;
    sums_t fin_sums;

    // configuration registers
    rdsc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register and running sums
    rdsc_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg       (cfg),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_sums  (fin_sums)
    );

    // result forming and output register
    rdsc_finish u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin_sums  (fin_sums),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // input only backs up behind a waiting hand-off
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> fin_valid)
        else $error("input stalled with no result pending");

    // a new result on the output comes from a hand-off
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(fin_valid))
        else $error("result appeared without a hand-off");

    // image_ok means neither fix was applied
    a_ok_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[2] == !(m_tuser[0] || m_tuser[1])))
        else $error("image_ok inconsistent with fix flags");

    // a pending hand-off holds while the output is blocked
    a_handoff_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fin_valid && !fin_ready |=> fin_valid && $stable(fin_sums))
        else $error("hand-off lost while output blocked");

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: image checksum fixer block test
// Streams images of addressed words into the block and checks each result
// against an in-bench model of the two wrapping sums, the captured balance
// and check words and the corrections given on the last word. Runs directed
// images, then random well-formed and broken images under several register
// settings and back-pressure mixes.
// ----------------------------------------------------------------------------
module testbench;

    localparam int AW          = rdsc_pkg::ADDR_BITS;
    localparam int STALL_LIMIT = 2000;

    // predicted running state of one image
    typedef struct packed {
        logic [31:0] region;
        logic [31:0] checked;
        logic [31:0] balance_seen;
        logic [31:0] check_seen;
    } image_sums_t;

    // one result of the block
    typedef struct packed {
        logic [31:0] balance_word;
        logic [31:0] check_word;
        logic        balance_fixed;
        logic        check_fixed;
        logic        image_ok;
    } image_fix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [rdsc_pkg::IN_TDATA_W-1:0]  s_tdata = '0;   // rom_word, word_address
    logic                             s_tlast = 1'b0; // last_word
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [rdsc_pkg::OUT_TDATA_W-1:0] m_tdata;        // balance_word, check_word
    logic [rdsc_pkg::OUT_TUSER_W-1:0] m_tuser;        // balance_fixed, check_fixed,
                                                      // image_ok
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [rdsc_pkg::APB_ADDR_W-1:0]  paddr = '0;
    logic [rdsc_pkg::APB_DATA_W-1:0]  pwdata = '0;
    logic [rdsc_pkg::APB_DATA_W-1:0]  prdata;
    logic                             pready;

    // register copies, reset values
    logic [AW-1:0] cfg_balance_addr = 24'h008020;
    logic [31:0]   cfg_sum_target   = 32'h5aa5a55a;
    logic [AW-1:0] cfg_check_addr   = 24'h008000;

    image_sums_t live_sums = '0;
    image_fix_t  pending_fixes[$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          stalled_cycles = 0;
    int          send_idle_pct = 37;
    int          recv_idle_pct = 45;

    // image under construction
    logic [31:0]   img_words[$];
    logic [AW-1:0] img_addrs[$];

    rom_dual_sum_checksum_fixer i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // byte-wise complement, low byte negated
    function automatic logic [31:0] checksum_bytes(input logic [31:0] s);
        logic [31:0] r;
        r[31:8] = ~s[31:8];
        r[7:0]  = 8'h00 - s[7:0];
        return r;
    endfunction

    // eight bytes from the check address, no wrap at the top
    function automatic bit in_check_words(input logic [AW-1:0] a);
        return ({1'b0, a} >= {1'b0, cfg_check_addr}) &&
               ({1'b0, a} <= {1'b0, cfg_check_addr} + (AW + 1)'(7));
    endfunction

    // fold one word into the sums; on the last word form the result and clear
    function automatic bit absorb_word(inout image_sums_t st, input logic [31:0] w,
                                       input logic [AW-1:0] a, input bit last,
                                       output image_fix_t fix);
        logic [31:0] fresh_bal;
        logic [31:0] adjusted;
        fix = '0;
        if (a >= cfg_balance_addr)
            st.region += w;
        if (!in_check_words(a))
            st.checked += w;
        if (a == cfg_balance_addr)
            st.balance_seen = w;
        if (a == cfg_check_addr)
            st.check_seen = w;
        if (!last)
            return 1'b0;
        fresh_bal         = st.balance_seen + (cfg_sum_target - st.region);
        fix.balance_word  = fresh_bal;
        fix.balance_fixed = (st.region != cfg_sum_target);
        fix.check_fixed   = (checksum_bytes(st.checked) != st.check_seen);
        // recompute counts the balance correction unless it sits in the check words
        adjusted = st.checked;
        if (!in_check_words(cfg_balance_addr))
            adjusted += fresh_bal - st.balance_seen;
        fix.check_word = fix.check_fixed ? checksum_bytes(adjusted) : st.check_seen;
        fix.image_ok   = !fix.balance_fixed && !fix.check_fixed;
        st = '0;
        return 1'b1;
    endfunction

    function automatic void put_word(input logic [31:0] w, input logic [AW-1:0] a);
        img_words.push_back(w);
        img_addrs.push_back(a);
    endfunction

    // append, then move to a random place in the image
    function automatic void add_word(input logic [31:0] w, input logic [AW-1:0] a);
        int j;
        logic [31:0] tw;
        logic [AW-1:0] ta;
        put_word(w, a);
        j = $urandom_range(0, img_words.size() - 1);
        tw = img_words[j];
        ta = img_addrs[j];
        img_words[j] = img_words[img_words.size() - 1];
        img_addrs[j] = img_addrs[img_addrs.size() - 1];
        img_words[img_words.size() - 1] = tw;
        img_addrs[img_addrs.size() - 1] = ta;
    endfunction

    // half near the balance and check words, half anywhere
    function automatic logic [AW-1:0] pick_address();
        case ($urandom_range(0, 3))
            0: return AW'($urandom) & ~AW'(3);
            1: return cfg_balance_addr + AW'(4 * $urandom_range(0, 15));
            2: return cfg_check_addr + AW'(4 * $urandom_range(0, 7)) - AW'(12);
            default: return AW'($urandom);
        endcase
    endfunction

    // overwrite the latest balance word so the region sum hits the target
    function automatic void repair_balance();
        image_sums_t st;
        image_fix_t  fix;
        int          j;
        st = '0;
        fix = '0;
        j = -1;
        foreach (img_words[i])
        begin
            void'(absorb_word(st, img_words[i], img_addrs[i], i == img_words.size() - 1, fix));
            if (img_addrs[i] == cfg_balance_addr)
                j = i;
        end
        if (j >= 0)
            img_words[j] = fix.balance_word;
    endfunction

    // set both check words to the check value of the words as they stand
    function automatic void repair_check();
        logic [31:0] outside;
        outside = '0;
        foreach (img_words[i])
            if (!in_check_words(img_addrs[i]))
                outside += img_words[i];
        foreach (img_words[i])
            if (in_check_words(img_addrs[i]) && (img_addrs[i] == cfg_check_addr ||
                                                 img_addrs[i] == cfg_check_addr + AW'(4)))
                img_words[i] = checksum_bytes(outside);
    endfunction

    // one word request; predict once it is taken
    task automatic send_word(input logic [31:0] w, input logic [AW-1:0] a, input bit last);
        image_fix_t fix;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {a, w};
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
        if (absorb_word(live_sums, w, a, last, fix))
            pending_fixes.push_back(fix);
    endtask

    task automatic send_image();
        foreach (img_words[i])
            send_word(img_words[i], img_addrs[i], i == img_words.size() - 1);
        img_words.delete();
        img_addrs.delete();
    endtask

    // hold off until every result is back and the pipeline is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_fixes.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // write all three registers while idle
    task automatic write_config(input logic [AW-1:0] bal, input logic [31:0] target,
                                input logic [AW-1:0] chk);
        logic [31:0] values [3];
        logic [1:0]  regs [3];
        settle();
        values[0] = 32'(bal);
        values[1] = target;
        values[2] = 32'(chk);
        regs[0] = rdsc_pkg::REG_BALANCE_ADDRESS;
        regs[1] = rdsc_pkg::REG_SUM_TARGET;
        regs[2] = rdsc_pkg::REG_CHECK_ADDRESS;
        for (int k = 0; k < 3; k++)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {regs[k], 2'b00};
            pwdata  <= values[k];
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_balance_addr = bal;
        cfg_sum_target   = target;
        cfg_check_addr   = chk;
        @(posedge clk);
    endtask

    // hand-built images at the reset register values
    task automatic test_directed_images();
        logic [AW-1:0] layout [6];
        layout[0] = 24'h008000;
        layout[1] = 24'h008004;
        layout[2] = 24'h008010;
        layout[3] = 24'h008020;
        layout[4] = 24'h008024;
        layout[5] = 24'h008028;
        // clean image, then wrong balance with a check that matches the words
        for (int v = 0; v < 2; v++)
        begin
            foreach (layout[k])
                put_word($urandom, layout[k]);
            if (v == 0)
                repair_balance();
            repair_check();
            send_image();
        end
        // right balance, wrong check, extreme words and addresses
        put_word($urandom, 24'h008000);
        put_word($urandom, 24'h008004);
        put_word($urandom, 24'h008020);
        put_word(32'hffffffff, 24'hfffffc);
        put_word(32'h00000000, 24'h000000);
        repair_balance();
        send_image();
        // lone word: balance and check words both missing, unaligned top address
        put_word(32'hffffffff, 24'hffffff);
        send_image();
        // repeated balance and check addresses, latest copy wins
        put_word($urandom, 24'h008020);
        put_word($urandom, 24'h008000);
        put_word($urandom, 24'h008020);
        put_word($urandom, 24'h008000);
        put_word($urandom, 24'h007ffc);
        repair_balance();
        repair_check();
        send_image();
    endtask

    // balance word inside the check words: no correction term in the recompute
    task automatic test_balance_in_check_range();
        write_config(24'h000104, $urandom, 24'h000100);
        put_word($urandom, 24'h000100);
        put_word($urandom, 24'h000104);
        put_word($urandom, 24'h000200);
        send_image();
    endtask

    // mostly well-formed images with random content, some broken or noise
    task automatic test_random_images(input int item_budget);
        int stop_at;
        int kind;
        int body;
        stop_at = words_sent + item_budget;
        while (words_sent < stop_at)
        begin
            kind = $urandom_range(0, 9);
            body = ($urandom_range(0, 15) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 7);
            repeat (body) add_word($urandom, pick_address());
            if (kind <= 6)
            begin
                add_word($urandom, cfg_check_addr);
                add_word($urandom, cfg_check_addr + AW'(4));
                add_word($urandom, cfg_balance_addr);
                if ($urandom_range(0, 7) == 0)
                    add_word($urandom, cfg_balance_addr);
                if (kind <= 3 || $urandom_range(0, 1) == 1)
                    repair_balance();
                if (kind <= 3 || $urandom_range(0, 1) == 1)
                    repair_check();
            end
            else if (kind == 7)
            begin
                // one of balance or check word missing
                if ($urandom_range(0, 1) == 1)
                    add_word($urandom, cfg_balance_addr);
                else
                    add_word($urandom, cfg_check_addr);
                repair_balance();
            end
            else if (kind == 8)
            begin
                // noise anywhere in the address space
                foreach (img_addrs[i])
                    img_addrs[i] = AW'($urandom);
            end
            send_image();
            if ($urandom_range(0, 9) == 0)
                settle();
        end
    endtask

    // receiver stalls
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // result checker
    always @(posedge clk)
    begin : check_result
        image_fix_t got;
        image_fix_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.balance_word  = m_tdata[31:0];
            got.check_word    = m_tdata[63:32];
            got.balance_fixed = m_tuser[0];
            got.check_fixed   = m_tuser[1];
            got.image_ok      = m_tuser[2];
            if (pending_fixes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: bal %h chk %h flags %b%b%b",
                             got.balance_word, got.check_word,
                             got.balance_fixed, got.check_fixed, got.image_ok);
            end
            else
            begin
                want = pending_fixes.pop_front();
                if (got.balance_word !== want.balance_word ||
                    got.check_word !== want.check_word ||
                    got.balance_fixed !== want.balance_fixed ||
                    got.check_fixed !== want.check_fixed ||
                    got.image_ok !== want.image_ok)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result mismatch: expected bal %h chk %h flags %b%b%b",
                                 want.balance_word, want.check_word,
                                 want.balance_fixed, want.check_fixed, want.image_ok);
                        $display("                 got      bal %h chk %h flags %b%b%b",
                                 got.balance_word, got.check_word,
                                 got.balance_fixed, got.check_fixed, got.image_ok);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no request taken on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_images();
        test_balance_in_check_range();

        write_config(24'hfffffc, 32'hffffffff, 24'h000000);
        test_random_images(170);

        send_idle_pct = 45;
        recv_idle_pct = 37;
        write_config(24'h000000, 32'h00000000, 24'hfffffc);
        test_random_images(170);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        begin : quiet_phase
            logic [AW-1:0] chk;
            chk = AW'($urandom_range(0, 24'h7fff00)) & ~AW'(3);
            write_config(chk + AW'(8 + 4 * $urandom_range(0, 64)), $urandom, chk);
        end
        test_random_images(170);

        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_fixes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
